// ===== rtl/core/qsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and constants of the quoted string unescape core.
// ----------------------------------------------------------------------------
package qsu_pkg;

	localparam int QDepth = 2;
	localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} res_t;

	// one queue word: the results that one input byte causes
	typedef struct packed {
		logic pair;
		res_t r0;
		res_t r1;
	} ent_t;

	function automatic res_t make_res(logic [7:0] data, logic [1:0] kind);
		res_t r;
		r.data = data;
		r.kind = kind;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

// ===== rtl/core/qsu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_front
// Accepts text bytes, tracks quote and escape state, and builds queue words.
// ----------------------------------------------------------------------------
module qsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_byte,
	input  logic          q_full,
	output logic          q_push,
	output qsu_pkg::ent_t q_wdata
);
	import qsu_pkg::*;

	localparam logic [2:0] M_OUT = 3'd0;
	localparam logic [2:0] M_IN  = 3'd1;
	localparam logic [2:0] M_ESC = 3'd2;
	localparam logic [2:0] M_HEX = 3'd3;
	localparam logic [2:0] M_OCT = 3'd4;
	localparam logic [2:0] M_ERR = 3'd5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] VAL_BEL  = 8'h07;
	localparam logic [7:0] VAL_BS   = 8'h08;
	localparam logic [7:0] VAL_FF   = 8'h0C;
	localparam logic [7:0] VAL_LF   = 8'h0A;
	localparam logic [7:0] VAL_TAB  = 8'h09;
	localparam logic [1:0] HEX_LIM  = 2'd2;
	localparam logic [1:0] OCT_LIM  = 2'd3;

	logic [2:0] mode_q, mode_d;
	logic [1:0] cnt_q, cnt_d, cnt_n;
	logic [8:0] val_q, val_d, val_sum;
	logic [1:0] nres;
	res_t       r0, r1;
	logic       dig_ok;
	logic [3:0] dig_val;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		dig_ok  = 1'b0;
		dig_val = in_byte[3:0];
		if (mode_q == M_HEX) begin
			if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
				dig_ok = 1'b1;
			end else if ((in_byte >= CH_LA && in_byte <= CH_LF) ||
					(in_byte >= CH_UA && in_byte <= CH_UF)) begin
				dig_ok  = 1'b1;
				dig_val = in_byte[3:0] + 4'd9;
			end
		end else begin
			dig_ok = (in_byte >= CH_ZERO) && (in_byte < CH_EIGHT);
		end
		if (mode_q == M_HEX) begin
			val_sum = {val_q[4:0], dig_val};
		end else begin
			val_sum = {val_q[5:0], dig_val[2:0]};
		end
		cnt_n = cnt_q + 2'd1;
	end

	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		val_d  = val_q;
		nres   = 2'd0;
		r0     = make_res(CH_NUL, KIND_DATA);
		r1     = make_res(CH_NUL, KIND_DATA);
		case (mode_q)
			M_IN: begin
				if (in_byte == CH_NUL) begin
					r0     = make_res(CH_NUL, KIND_ERR);
					nres   = 2'd1;
					mode_d = M_OUT;
				end else if (in_byte == CH_QUOTE) begin
					mode_d = M_OUT;
				end else if (in_byte == CH_BSL) begin
					mode_d = M_ESC;
				end else begin
					r0   = make_res(in_byte, KIND_DATA);
					nres = 2'd1;
				end
			end
			M_ESC: begin
				nres   = 2'd1;
				mode_d = M_IN;
				case (in_byte)
					CH_LA:    r0 = make_res(VAL_BEL, KIND_DATA);
					CH_LB:    r0 = make_res(VAL_BS, KIND_DATA);
					CH_LF:    r0 = make_res(VAL_FF, KIND_DATA);
					CH_LN:    r0 = make_res(VAL_LF, KIND_DATA);
					CH_LT:    r0 = make_res(VAL_TAB, KIND_DATA);
					CH_BSL,
					CH_QUOTE,
					CH_PCT:   r0 = make_res(in_byte, KIND_DATA);
					CH_LX: begin
						nres   = 2'd0;
						mode_d = M_HEX;
						cnt_d  = 2'd0;
						val_d  = 9'd0;
					end
					CH_ZERO: begin
						nres   = 2'd0;
						mode_d = M_OCT;
						cnt_d  = 2'd0;
						val_d  = 9'd0;
					end
					default: begin
						r0     = make_res(CH_NUL, KIND_ERR);
						mode_d = (in_byte == CH_NUL) ? M_OUT : M_ERR;
					end
				endcase
			end
			M_HEX, M_OCT: begin
				if (dig_ok) begin
					if (cnt_n >= ((mode_q == M_HEX) ? HEX_LIM : OCT_LIM)) begin
						cnt_d = 2'd0;
						val_d = 9'd0;
						nres  = 2'd1;
						if (val_sum != 9'd0) begin
							r0     = make_res(val_sum[7:0], KIND_DATA);
							mode_d = M_IN;
						end else begin
							r0     = make_res(CH_NUL, KIND_ERR);
							mode_d = M_ERR;
						end
					end else begin
						cnt_d = cnt_n;
						val_d = val_sum;
					end
				end else begin
					cnt_d = 2'd0;
					val_d = 9'd0;
					nres  = 2'd1;
					if (val_q != 9'd0) begin
						r0     = make_res(val_q[7:0], KIND_DATA);
						mode_d = M_IN;
						if (in_byte == CH_NUL) begin
							r1     = make_res(CH_NUL, KIND_ERR);
							nres   = 2'd2;
							mode_d = M_OUT;
						end else if (in_byte == CH_QUOTE) begin
							mode_d = M_OUT;
						end else if (in_byte == CH_BSL) begin
							mode_d = M_ESC;
						end else begin
							r1   = make_res(in_byte, KIND_DATA);
							nres = 2'd2;
						end
					end else begin
						r0     = make_res(CH_NUL, KIND_ERR);
						mode_d = (in_byte == CH_NUL) ? M_OUT : M_ERR;
					end
				end
			end
			M_ERR: begin
				if (in_byte == CH_NUL) begin
					mode_d = M_OUT;
				end
			end
			default: begin
				mode_d = M_OUT;
				if (in_byte == CH_NUL) begin
					r0   = make_res(CH_NUL, KIND_END);
					nres = 2'd1;
				end else if (in_byte == CH_QUOTE) begin
					mode_d = M_IN;
				end else begin
					r0   = make_res(in_byte, KIND_DATA);
					nres = 2'd1;
				end
			end
		endcase
		r0.last = (nres == 2'd1);
		r1.last = 1'b1;
	end

	assign q_push       = accept && (nres != 2'd0);
	assign q_wdata.pair = (nres == 2'd2);
	assign q_wdata.r0   = r0;
	assign q_wdata.r1   = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_OUT;
			cnt_q  <= 2'd0;
			val_q  <= 9'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			val_q  <= val_d;
		end
	end

endmodule

// ===== rtl/core/qsu_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_fifo
// Short word queue between the front and back parts.
// ----------------------------------------------------------------------------
module qsu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qsu_pkg::ent_t wdata,
	output logic          full,
	input  logic          pop,
	output qsu_pkg::ent_t rdata,
	output logic          empty
);
	import qsu_pkg::*;

	ent_t             mem_q [QDepth];
	logic [QPtrW-1:0] wptr_q, rptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == QCntW'(QDepth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/qsu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_back
// Unpacks queue words into single results held in the output register.
// ----------------------------------------------------------------------------
module qsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  qsu_pkg::ent_t q_rdata,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic [1:0]    kind,
	output logic          last
);
	import qsu_pkg::*;

	logic out_valid_q;
	res_t res_q;
	logic phase_q;
	logic load;
	res_t pick;

	assign load  = !out_valid_q || !out_stall;
	assign pick  = phase_q ? q_rdata.r1 : q_rdata.r0;
	assign q_pop = load && !q_empty && (!q_rdata.pair || phase_q);

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			res_q <= pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				phase_q <= q_rdata.pair && !phase_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = res_q.data;
	assign kind      = res_q.kind;
	assign last      = res_q.last;

endmodule

// ===== rtl/core/quoted_string_unescape_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescape_core
// Decodes C-style escapes in quoted text, one byte per cycle unless stalled.
//
//   channel  signals                          width
//   in       in_valid in_stall in_byte        8
//   out      out_valid out_stall out_byte     8
//            kind last                        2, 1
//
// One input byte is taken per cycle while the queue has room; the decode
// state updates in that same cycle. Results leave through a registered
// output one per cycle while out_stall is low, so a byte that ends a digit
// run with two results takes the output for both of them. Reset clears the
// decode state, the queue and the output valid; out_stall backs up into the
// two-word queue and then raises in_stall.
// ----------------------------------------------------------------------------
module quoted_string_unescape_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last
);
	import qsu_pkg::*;

	ent_t q_wdata, q_rdata;
	logic q_push, q_full, q_pop, q_empty;

	qsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	qsu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	qsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

endmodule
